// ===== rtl/radar_report_frame_parser_macros.svh =====
// ----------------------------------------------------------------------------
// Radar report frame parser assertion macros
// Concurrent assertion helpers for the parser modules, removed in synthesis.
// ----------------------------------------------------------------------------
`ifndef RADAR_REPORT_FRAME_PARSER_MACROS_SVH
`define RADAR_REPORT_FRAME_PARSER_MACROS_SVH
`ifndef SYNTHESIS
`define RRFP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define RRFP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define RRFP_ASSERT_IMPL(label, ante, cons)
`define RRFP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/rrfp_pkg.sv =====
// ----------------------------------------------------------------------------
// Radar report frame parser package
// Shared constants, frame markers, state types and link structures.
// ----------------------------------------------------------------------------
package rrfp_pkg;

  localparam int MAX_PAYLOAD    = 128;
  localparam int GATE_COUNT     = 16;
  localparam int CNT_W          = $clog2(MAX_PAYLOAD + 1);
  localparam int GATE_W         = (GATE_COUNT > 1) ? $clog2(GATE_COUNT) : 1;
  localparam int ENERGY_BASE    = 6;
  localparam int MIN_ENERGY_LEN = ENERGY_BASE + 4 * GATE_COUNT;
  localparam int QUEUE_DEPTH    = 2;
  localparam int TDATA_W        = 64;

  localparam logic [7:0]  HEAD_FIRST     = 8'hF4;
  localparam logic [31:0] HEAD_WORD      = 32'hF1F2F3F4;
  localparam logic [31:0] TAIL_WORD      = 32'hF5F6F7F8;
  localparam logic [7:0]  TYPE_A         = 8'h01;
  localparam logic [7:0]  TYPE_B         = 8'h02;
  localparam logic [15:0] MIN_REPORT_LEN = 16'd6;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEAD,
    PH_LEN,
    PH_DATA,
    PH_TAIL
  } phase_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_LOAD
  } back_state_t;

  typedef struct packed {
    logic [7:0]  status;
    logic [15:0] distance;
    logic        fresh;
    logic        have_energy;
    logic        bank;
  } job_t;

  typedef struct packed {
    logic              en;
    logic [GATE_W:0]   addr;
    logic [31:0]       data;
  } ewr_t;

endpackage

// ===== rtl/rrfp_front.sv =====
// ----------------------------------------------------------------------------
// Radar report frame parser front end
// Hunts for frames, captures the report fields and stages the gate energies.
// ----------------------------------------------------------------------------
module rrfp_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [7:0]     s_tdata,  // [7:0] rx_byte
  input  logic           back_busy,
  input  logic           q_full,
  output logic           q_push,
  output rrfp_pkg::job_t q_job,
  output rrfp_pkg::ewr_t ewr
);
  import rrfp_pkg::*;

  phase_t           phase;
  phase_t           phase_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_inc;
  logic [CNT_W-1:0] energy_off;
  logic             match;
  logic             byte_ok;
  logic             marker_done;
  logic             data_done;
  logic             in_energy;
  logic             frame_ok;
  logic             accept;
  logic             bank;
  logic             have_energy;
  logic [15:0]      frame_length;
  logic [7:0]       ptype;
  logic [7:0]       status;
  logic [15:0]      distance;
  logic [31:0]      word;
  logic [7:0]       head_exp;
  logic [7:0]       tail_exp;

  assign count_inc   = count + 1'b1;
  assign energy_off  = count - CNT_W'(ENERGY_BASE);
  assign in_energy   = (count >= CNT_W'(ENERGY_BASE)) && (count < CNT_W'(MIN_ENERGY_LEN));
  assign head_exp    = HEAD_WORD[{count[1:0], 3'b000} +: 8];
  assign tail_exp    = TAIL_WORD[{count[1:0], 3'b000} +: 8];
  assign byte_ok     = (s_tdata == ((phase == PH_HEAD) ? head_exp : tail_exp));
  assign marker_done = (count[1:0] == 2'd3);
  assign data_done   = (16'(count_inc) >= frame_length) ||
                       (count_inc >= CNT_W'(MAX_PAYLOAD));
  assign frame_ok    = match && byte_ok && ((ptype == TYPE_A) || (ptype == TYPE_B)) &&
                       (frame_length >= MIN_REPORT_LEN);
  assign accept      = s_tvalid && s_tready;

  assign q_job.status      = status;
  assign q_job.distance    = distance;
  assign q_job.fresh       = (frame_length >= 16'(MIN_ENERGY_LEN));
  assign q_job.have_energy = q_job.fresh || have_energy;
  assign q_job.bank        = q_job.fresh ? ~bank : bank;

  always_comb begin
    phase_next = phase;
    if (accept) begin
      unique case (phase)
        PH_IDLE: if (s_tdata == HEAD_FIRST) phase_next = PH_HEAD;
        PH_HEAD: if (marker_done) phase_next = (match && byte_ok) ? PH_LEN : PH_IDLE;
        PH_LEN:  if (count[0]) phase_next = PH_DATA;
        PH_DATA: if (data_done) phase_next = PH_TAIL;
        PH_TAIL: if (marker_done) phase_next = PH_IDLE;
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  always_comb begin
    s_tready  = 1'b1;
    q_push    = 1'b0;
    ewr.en    = 1'b0;
    ewr.addr  = {~bank, energy_off[GATE_W+1:2]};
    ewr.data  = {s_tdata, word[31:8]};
    unique case (phase)
      PH_DATA: begin
        s_tready = !(in_energy && back_busy);
        ewr.en   = s_tvalid && in_energy && !back_busy && (energy_off[1:0] == 2'b11);
      end
      PH_TAIL: begin
        s_tready = !(marker_done && q_full);
        q_push   = s_tvalid && marker_done && !q_full && frame_ok;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      count       <= '0;
      match       <= 1'b0;
      bank        <= 1'b0;
      have_energy <= 1'b0;
    end else begin
      phase <= phase_next;
      if (accept) begin
        unique case (phase)
          PH_IDLE: begin
            count <= CNT_W'(1);
            match <= 1'b1;
          end
          PH_HEAD: begin
            match <= match && byte_ok;
            count <= marker_done ? '0 : count_inc;
          end
          PH_LEN: begin
            count <= count[0] ? '0 : CNT_W'(1);
          end
          PH_DATA: begin
            count <= data_done ? '0 : count_inc;
            match <= 1'b1;
          end
          PH_TAIL: begin
            match <= match && byte_ok;
            count <= marker_done ? '0 : count_inc;
            if (q_push) begin
              bank        <= q_job.bank;
              have_energy <= q_job.have_energy;
            end
          end
          default: begin
            count <= '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (phase == PH_LEN)) begin
      if (count[0]) begin
        frame_length[15:8] <= s_tdata;
      end else begin
        frame_length <= {8'h00, s_tdata};
      end
    end
    if (accept && (phase == PH_DATA)) begin
      word <= {s_tdata, word[31:8]};
      if (count == CNT_W'(0)) ptype <= s_tdata;
      if (count == CNT_W'(1)) status <= s_tdata;
      if (count == CNT_W'(2)) distance[7:0] <= s_tdata;
      if (count == CNT_W'(3)) distance[15:8] <= s_tdata;
    end
  end

endmodule

// ===== rtl/rrfp_queue.sv =====
// ----------------------------------------------------------------------------
// Radar report frame parser job queue
// Short queue of accepted frame reports between the front and back ends.
// ----------------------------------------------------------------------------
`include "radar_report_frame_parser_macros.svh"

module rrfp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rrfp_pkg::job_t push_job,
  input  logic           pop,
  output rrfp_pkg::job_t pop_job,
  output logic           empty,
  output logic           full
);
  import rrfp_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  job_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   fill;

  assign empty   = (fill == '0);
  assign full    = (fill == (PTR_W+1)'(QUEUE_DEPTH));
  assign pop_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  `RRFP_ASSERT_IMPL(a_no_push_full, push, !full)
  `RRFP_ASSERT_IMPL(a_no_pop_empty, pop, !empty)
  `RRFP_ASSERT_IMPL(a_fill_bound, 1'b1, fill <= (PTR_W+1)'(QUEUE_DEPTH))

endmodule

// ===== rtl/rrfp_back.sv =====
// ----------------------------------------------------------------------------
// Radar report frame parser back end
// Holds the gate energy banks and sends one result per gate for each report.
// ----------------------------------------------------------------------------
`include "radar_report_frame_parser_macros.svh"

module rrfp_back (
  input  logic           clk,
  input  logic           rst,
  input  rrfp_pkg::ewr_t ewr,
  input  logic           q_empty,
  input  rrfp_pkg::job_t q_job,
  output logic           q_pop,
  output logic           busy,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [63:0]    m_tdata,  // [7:0] status_byte, [23:8] distance_cm,
                                   // [27:24] gate_number, [59:28] energy_word
  output logic           m_tuser,  // [0] energies_fresh
  output logic           m_tlast   // last_gate
);
  import rrfp_pkg::*;

  back_state_t       state;
  back_state_t       state_next;
  job_t              job;
  logic [GATE_W-1:0] gate;
  logic              last;
  logic              out_free;
  logic              load;
  logic [31:0]       energy_mem [2 * GATE_COUNT];
  logic [31:0]       rd_data;
  logic [7:0]        out_status;
  logic [15:0]       out_distance;
  logic [3:0]        out_gate;
  logic [31:0]       out_energy;

  assign last     = (gate == GATE_W'(GATE_COUNT - 1));
  assign out_free = !m_tvalid || m_tready;
  assign busy     = (state != BK_IDLE);
  assign m_tdata  = {4'h0, out_energy, out_gate, out_distance, out_status};

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (!q_empty) state_next = BK_READ;
      BK_READ: state_next = BK_LOAD;
      BK_LOAD: if (out_free) state_next = last ? BK_IDLE : BK_READ;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    load  = 1'b0;
    unique case (state)
      BK_IDLE: q_pop = !q_empty;
      BK_LOAD: load = out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BK_IDLE;
      gate     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= load || (m_tvalid && !m_tready);
      if (q_pop) begin
        gate <= '0;
      end else if (load && !last) begin
        gate <= gate + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job <= q_job;
    end
    if (load) begin
      out_status   <= job.status;
      out_distance <= job.distance;
      out_gate     <= 4'(gate);
      out_energy   <= job.have_energy ? rd_data : 32'h0;
      m_tuser      <= job.fresh;
      m_tlast      <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (ewr.en) begin
      energy_mem[ewr.addr] <= ewr.data;
    end
    rd_data <= energy_mem[{job.bank, gate}];
  end

  `RRFP_ASSERT_NEXT(a_read_then_load, state == BK_READ, state == BK_LOAD)
  `RRFP_ASSERT_IMPL(a_pop_when_idle, q_pop, (state == BK_IDLE) && !q_empty)
  `RRFP_ASSERT_IMPL(a_last_on_top_gate, m_tvalid && m_tlast, out_gate == 4'(GATE_COUNT - 1))
  `RRFP_ASSERT_IMPL(a_no_write_read_bank, ewr.en && busy, ewr.addr[GATE_W] != job.bank)

endmodule

// ===== rtl/radar_report_frame_parser.sv =====
// ----------------------------------------------------------------------------
// Radar report frame parser
// One received byte is taken per cycle during a frame, except in the stalls below.
// A valid report is queued, then leaves as 16 results, each after an energy bank read;
// its last tail byte waits while the report queue is full.
// Energy bytes of the next frame wait while an earlier report is still queued or sent.
// Reset is synchronous and active high: hunting restarts and stored energies read zero.
// ----------------------------------------------------------------------------
module radar_report_frame_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [7:0] status_byte, [23:8] distance_cm,
                                 // [27:24] gate_number, [59:28] energy_word
  output logic        m_tuser,   // [0] energies_fresh
  output logic        m_tlast    // last_gate
);
  import rrfp_pkg::*;

  job_t push_job;
  job_t pop_job;
  ewr_t ewr;
  logic q_push;
  logic q_pop;
  logic q_empty;
  logic q_full;
  logic back_active;
  logic back_busy;

  assign back_busy = !q_empty || back_active;

  rrfp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .back_busy (back_busy),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job),
    .ewr       (ewr)
  );

  rrfp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  rrfp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .ewr      (ewr),
    .q_empty  (q_empty),
    .q_job    (pop_job),
    .q_pop    (q_pop),
    .busy     (back_active),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
